// ===== rtl/mvt_pkg.sv =====
// Shared types and constants for the 4x4 fixed-point matrix-vector transform.
// Used by every module of the block; depends on nothing else.
package mvt_pkg;

  localparam int N             = 4;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int IDX_W         = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // One word travelling down the chain of column cells.
  typedef struct packed {
    logic               valid;
    logic               op;
    logic [IDX_W-1:0]   idx;
    data_t              value;
    data_t [N-1:0]      vec;
    sum_t  [N-1:0]      acc;
  } tok_t;

endpackage

// ===== rtl/mvt_cell.sv =====
// One column cell of the chain: holds one matrix column, multiplies it by its
// vector component and adds the products to the running row sums. Uses mvt_pkg.
module mvt_cell #(
  parameter int COL = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  mvt_pkg::tok_t tok_in,
  output mvt_pkg::tok_t tok_out
);
  import mvt_pkg::*;

  data_t                     col [N];
  tok_t                      tok_a;
  logic signed [PROD_W-1:0]  prod      [N];
  logic signed [PROD_W-1:0]  prod_next [N];
  tok_t                      tok_out_next;
  logic                      wr_hit;

  assign wr_hit = tok_in.valid && (tok_in.op == OP_LOAD) && (tok_in.idx[1:0] == COL[1:0]);

  always_comb begin
    for (int r = 0; r < N; r++) begin
      prod_next[r] = $signed(col[r]) * $signed(tok_in.vec[COL]);
    end
  end

  always_comb begin
    tok_out_next = tok_a;
    for (int r = 0; r < N; r++) begin
      tok_out_next.acc[r] = tok_a.acc[r] + sum_t'(prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a.valid   <= 1'b0;
      tok_out.valid <= 1'b0;
      col           <= '{default: '0};
    end else if (en) begin
      tok_a   <= tok_in;
      prod    <= prod_next;
      tok_out <= tok_out_next;
      if (wr_hit) begin
        col[tok_in.idx[IDX_W-1:2]] <= tok_in.value;
      end
    end
  end

endmodule

// ===== rtl/mvt_out.sv =====
// Output end of the chain: shifts and saturates the row sums, then holds the
// result in an output register backed by one skid register. Uses mvt_pkg.
module mvt_out #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  mvt_pkg::tok_t tok_in,
  output logic          en,
  output logic          out_valid,
  input  logic          out_ready,
  output mvt_pkg::data_t out_x,
  output mvt_pkg::data_t out_y,
  output mvt_pkg::data_t out_z,
  output mvt_pkg::data_t out_w,
  output logic          saturated
);
  import mvt_pkg::*;

  typedef struct packed {
    data_t [N-1:0] comp;
    logic          sat;
  } res_t;

  localparam data_t MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  res_t res_next;
  res_t res;
  res_t skid;
  logic skid_valid;
  logic push;
  sum_t sh [N];

  always_comb begin
    res_next = '0;
    for (int r = 0; r < N; r++) begin
      sh[r] = $signed(tok_in.acc[r]) >>> FRAC_BITS;
      if ((&sh[r][SUM_W-1:DATA_W-1]) || !(|sh[r][SUM_W-1:DATA_W-1])) begin
        res_next.comp[r] = sh[r][DATA_W-1:0];
      end else begin
        res_next.comp[r] = sh[r][SUM_W-1] ? MAX_NEG : MAX_POS;
        res_next.sat     = 1'b1;
      end
    end
  end

  assign en   = !skid_valid;
  assign push = en && tok_in.valid && (tok_in.op == OP_XFORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid       <= res_next;
        skid_valid <= 1'b1;
      end else begin
        res       <= res_next;
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_x     = res.comp[0];
  assign out_y     = res.comp[1];
  assign out_z     = res.comp[2];
  assign out_w     = res.comp[3];
  assign saturated = res.sat;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the output register is empty");

  a_push_to_empty: assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> (out_valid && !skid_valid))
    else $error("result pushed into an empty output was not presented");

  a_push_on_stall: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("result pushed during a stall was not caught by the skid register");

endmodule

// ===== rtl/matrix_vector_transform_4x4.sv =====
// Top level of the 4x4 fixed-point matrix-vector transform.
// Instantiates four mvt_cell column cells and mvt_out; uses mvt_pkg.
//
// Usage: one input channel (in_valid / in_ready) carries a word with op,
// entry_index, entry_value and vec_x..vec_w. A load word (op = 0) writes one
// matrix entry in row-major order and gives no result. A transform word
// (op = 1) gives one result word on the output channel (out_valid /
// out_ready): the four row dot products, shifted right arithmetically by
// FRAC_BITS and saturated to signed 32 bits, with saturated set when any of
// them was clipped.
// The matrix lives in a chain of four column cells, each two register stages
// deep (multiply, then add to the running row sums), and every word, loads
// included, moves one stage per cycle while in_ready is high. A load
// therefore reaches each column in the same order as the transforms
// around it, so no word waits on another. Throughput is one word per cycle
// while in_ready is high; results are registered after the eight chain stages.
// Reset clears the matrix to zero and empties the chain and output.
// When the receiver stalls, one further result is caught by a skid register
// and then in_ready falls, freezing the whole chain until the skid is empty.
module matrix_vector_transform_4x4 #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [mvt_pkg::IDX_W-1:0]    entry_index,
  input  mvt_pkg::data_t               entry_value,
  input  mvt_pkg::data_t               vec_x,
  input  mvt_pkg::data_t               vec_y,
  input  mvt_pkg::data_t               vec_z,
  input  mvt_pkg::data_t               vec_w,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mvt_pkg::data_t               out_x,
  output mvt_pkg::data_t               out_y,
  output mvt_pkg::data_t               out_z,
  output mvt_pkg::data_t               out_w,
  output logic                         saturated
);
  import mvt_pkg::*;

  // chain[c] feeds column cell c; chain[N] leaves the last cell.
  tok_t chain [N+1];
  logic en;

  // The whole chain advances together; while it advances, a valid word at
  // the input is accepted, so the token's valid bit is simply in_valid.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = in_valid;
    chain[0].op    = op;
    chain[0].idx   = entry_index;
    chain[0].value = entry_value;
    chain[0].vec   = {vec_w, vec_z, vec_y, vec_x};
  end

  assign in_ready = en;

  for (genvar c = 0; c < N; c++) begin : g_cell
    mvt_cell #(
      .COL(c)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tok_in (chain[c]),
      .tok_out(chain[c+1])
    );
  end

  mvt_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .tok_in   (chain[N]),
    .en       (en),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w),
    .saturated(saturated)
  );

endmodule
